[design/fixed_point_alu_assert.svh]
// Assertion macros for the fixed-point ALU.
// Included by the modules that check their own logic; no other dependencies.
`ifndef FIXED_POINT_ALU_ASSERT_SVH
`define FIXED_POINT_ALU_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define FPA_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define FPA_ASSERT_RST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define FPA_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define FPA_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

[design/fpa_pkg.sv]
// Shared types, opcodes and constants of the fixed-point ALU.
// No dependencies.
package fpa_pkg;
    localparam int unsigned W = 32;

    typedef enum logic [3:0] {
        OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
        OP_GT = 4'd4, OP_LT = 4'd5, OP_GE = 4'd6, OP_LE = 4'd7,
        OP_EQ = 4'd8, OP_NE = 4'd9, OP_MIN = 4'd10, OP_MAX = 4'd11,
        OP_INC = 4'd12, OP_DEC = 4'd13, OP_TOINT = 4'd14, OP_FROMINT = 4'd15
    } t_op;

    typedef enum logic [1:0] {
        ST_OK = 2'd0, ST_OVF = 2'd1, ST_DIVZ = 2'd2
    } t_status;

    // Item travelling down the row of cells.
    typedef struct packed {
        logic          vld;
        logic [W-1:0]  value;
        logic          cmp;
        t_status       status;
        logic          div;    // item still needs division work
        logic          rnd;    // exit cell rounds, signs and saturates quo
        logic          neg;    // result sign for mul and div
        logic [63:0]   rem;    // division partial remainder
        logic [63:0]   num;    // dividend bits still to shift in
        logic [31:0]   den;    // divisor magnitude
        logic [63:0]   quo;    // quotient bits collected so far
    } t_item;
endpackage

[design/fpa_div_cell.sv]
// One restoring-division cell: each cell retires a fixed number of quotient bits.
// Depends on fpa_pkg.
module fpa_div_cell #(
    parameter int unsigned BITS = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  fpa_pkg::t_item i_item,
    output fpa_pkg::t_item o_item
);
    fpa_pkg::t_item r_item;
    fpa_pkg::t_item n_item;

    always_comb begin
        logic [64:0] trial;
        n_item = i_item;
        for (int k = 0; k < BITS; k++) begin
            n_item.rem = {n_item.rem[62:0], n_item.num[63]};
            n_item.num = {n_item.num[62:0], 1'b0};
            trial = {1'b0, n_item.rem} - {33'd0, n_item.den};
            if (!trial[64]) begin
                n_item.rem = trial[63:0];
                n_item.quo = {n_item.quo[62:0], 1'b1};
            end else begin
                n_item.quo = {n_item.quo[62:0], 1'b0};
            end
        end
        if (!i_item.div) begin
            n_item = i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item.vld <= 1'b0;
        end else if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_item = r_item;
endmodule

[design/fpa_front.sv]
// Entry cell: decodes the opcode, does the operations other than division, including the multiply,
// and prepares the division operands. Depends on fpa_pkg.
module fpa_front #(
    parameter int unsigned FRAC_BITS = 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_vld,
    input  logic [3:0]     i_action,
    input  logic [31:0]    i_a,
    input  logic [31:0]    i_b,
    output fpa_pkg::t_item o_item
);
    fpa_pkg::t_item r_item;
    fpa_pkg::t_item n_item;

    logic signed [32:0] sa, sb;
    logic [31:0] ma, mb;
    logic [63:0] prod;
    logic [63:0] big;

    function automatic logic [31:0] sat(input logic signed [65:0] v,
                                        output logic ovf);
        ovf = 1'b0;
        if (v > 66'sd2147483647) begin
            ovf = 1'b1;
            sat = 32'h7FFF_FFFF;
        end else if (v < -66'sd2147483648) begin
            ovf = 1'b1;
            sat = 32'h8000_0000;
        end else begin
            sat = v[31:0];
        end
    endfunction

    always_comb begin
        logic ovf;
        logic signed [65:0] wide;
        sa = {i_a[31], i_a};
        sb = {i_b[31], i_b};
        ma = i_a[31] ? 32'(-i_a) : i_a;
        mb = i_b[31] ? 32'(-i_b) : i_b;
        prod = {32'd0, ma} * {32'd0, mb};
        big = {32'd0, ma} << FRAC_BITS;
        wide = '0;
        ovf = 1'b0;
        n_item = '0;
        n_item.vld = i_vld;
        n_item.status = fpa_pkg::ST_OK;
        case (fpa_pkg::t_op'(i_action))
            fpa_pkg::OP_ADD: wide = 66'(sa + sb);
            fpa_pkg::OP_SUB: wide = 66'(sa - sb);
            fpa_pkg::OP_MUL: begin
                // The exit cell rounds on the dropped bit, applies the sign
                // and saturates, as it does for a quotient.
                n_item.rnd = 1'b1;
                n_item.neg = i_a[31] ^ i_b[31];
                n_item.quo = prod >> FRAC_BITS;
                n_item.rem = 64'(prod[FRAC_BITS-1]);
                n_item.den = 32'd1;
            end
            fpa_pkg::OP_GT: n_item.cmp = sa > sb;
            fpa_pkg::OP_LT: n_item.cmp = sa < sb;
            fpa_pkg::OP_GE: n_item.cmp = sa >= sb;
            fpa_pkg::OP_LE: n_item.cmp = sa <= sb;
            fpa_pkg::OP_EQ: n_item.cmp = sa == sb;
            fpa_pkg::OP_NE: n_item.cmp = sa != sb;
            fpa_pkg::OP_MIN: wide = 66'((sa < sb) ? sa : sb);
            fpa_pkg::OP_MAX: wide = 66'((sa > sb) ? sa : sb);
            fpa_pkg::OP_INC: wide = 66'(sa + 33'sd1);
            fpa_pkg::OP_DEC: wide = 66'(sa - 33'sd1);
            fpa_pkg::OP_TOINT: begin
                wide = i_a[31] ? -66'(ma >> FRAC_BITS) : 66'(ma >> FRAC_BITS);
            end
            fpa_pkg::OP_FROMINT: begin
                wide = i_a[31] ? -$signed({2'b0, big}) : $signed({2'b0, big});
            end
            default: wide = '0;
        endcase
        n_item.value = sat(wide, ovf);
        if (ovf) begin
            n_item.status = fpa_pkg::ST_OVF;
        end
        if (fpa_pkg::t_op'(i_action) == fpa_pkg::OP_DIV) begin
            if (mb == 32'd0) begin
                n_item.value = i_a[31] ? 32'h8000_0000 : 32'h7FFF_FFFF;
                n_item.status = fpa_pkg::ST_DIVZ;
            end else begin
                n_item.div = 1'b1;
                n_item.rnd = 1'b1;
                n_item.neg = i_a[31] ^ i_b[31];
                n_item.num = big;
                n_item.den = mb;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item.vld <= 1'b0;
        end else if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_item = r_item;
endmodule

[design/fpa_back.sv]
// Exit cell: rounds and saturates the finished quotient or product.
// Depends on fpa_pkg and the assertion macro header.
`include "fixed_point_alu_assert.svh"
module fpa_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  fpa_pkg::t_item i_item,
    output logic           o_vld,
    output logic [31:0]    o_value,
    output logic           o_cmp,
    output logic [1:0]     o_status
);
    logic        r_vld;
    logic [31:0] r_value;
    logic        r_cmp;
    logic [1:0]  r_status;
    logic [31:0] n_value;
    logic [1:0]  n_status;

    always_comb begin
        logic [64:0] q;
        logic signed [65:0] s;
        q = {1'b0, i_item.quo};
        // Round half away from zero on the magnitude: twice the remainder
        // reaching the divisor means the dropped part is at least one half.
        if (({1'b0, i_item.rem} << 1) >= {33'd0, i_item.den}) begin
            q = q + 65'd1;
        end
        s = i_item.neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
        n_value = i_item.value;
        n_status = i_item.status;
        if (i_item.rnd) begin
            n_status = fpa_pkg::ST_OK;
            if (s > 66'sd2147483647) begin
                n_value = 32'h7FFF_FFFF;
                n_status = fpa_pkg::ST_OVF;
            end else if (s < -66'sd2147483648) begin
                n_value = 32'h8000_0000;
                n_status = fpa_pkg::ST_OVF;
            end else begin
                n_value = s[31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_item.vld;
            r_value <= n_value;
            r_cmp <= i_item.cmp;
            r_status <= n_status;
        end
    end

    assign o_vld = r_vld;
    assign o_value = r_value;
    assign o_cmp = r_cmp;
    assign o_status = r_status;

    `FPA_ASSERT_IMPL(a_status_code, i_clk, i_rst_n, !r_vld || r_status != 2'd3, "bad status")
    `FPA_ASSERT_IMPL(a_cmp_zero, i_clk, i_rst_n, !(r_vld && r_cmp) || r_value == 32'd0, "cmp value")
    `FPA_ASSERT_RST(a_reset, i_clk, $past(!i_rst_n) |-> !r_vld, "valid after reset")
endmodule

[design/fixed_point_alu.sv]
// Top level of the signed fixed-point ALU: entry cell, a row of division cells
// and an exit cell. Depends on fpa_pkg, fpa_front, fpa_div_cell, fpa_back.
//
//  Channel  Direction  Payload
//  s_axis   in         tdata = action[3:0], operand_a[35:4], operand_b[67:36]
//  m_axis   out        tdata = result_value[31:0], compare_true[32], status[34:33]
//
// Every item passes through the same row of cells, one new item per cycle while
// the output is not stalled. An item is registered in the entry cell, in each
// division cell of the row in turn and in the exit cell; each division cell
// retires DIV_BITS_PER_CELL quotient bits.
// The whole row advances only when the output register is free or being read,
// so a stall at the master side holds every cell. Reset is synchronous and
// clears only the valid bits.
`include "fixed_point_alu_assert.svh"
module fixed_point_alu #(
    parameter int unsigned FRAC_BITS = 8,
    parameter int unsigned DIV_BITS_PER_CELL = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // action, operand_a, operand_b
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // result_value, compare_true, status
);
    localparam int unsigned NCELL = 64 / DIV_BITS_PER_CELL;

    fpa_pkg::t_item chain [NCELL+1];
    logic        en;
    logic        out_vld;
    logic [31:0] out_value;
    logic        out_cmp;
    logic [1:0]  out_status;

    // The row moves whenever the last register is empty or being taken.
    assign en = !out_vld || m_axis_tready;
    assign s_axis_tready = en;

    fpa_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_vld(s_axis_tvalid),
        .i_action(s_axis_tdata[3:0]),
        .i_a(s_axis_tdata[35:4]),
        .i_b(s_axis_tdata[67:36]),
        .o_item(chain[0])
    );

    for (genvar g = 0; g < NCELL; g++) begin : g_div
        fpa_div_cell #(.BITS(DIV_BITS_PER_CELL)) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
            .i_item(chain[g]), .o_item(chain[g+1])
        );
    end

    fpa_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_item(chain[NCELL]),
        .o_vld(out_vld), .o_value(out_value), .o_cmp(out_cmp), .o_status(out_status)
    );

    assign m_axis_tvalid = out_vld;
    assign m_axis_tdata = {5'd0, out_status, out_cmp, out_value};

    `FPA_ASSERT_IMPL(a_hold, i_clk, i_rst_n, (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid, "drop")
    `FPA_ASSERT_IMPL(a_ready, i_clk, i_rst_n, s_axis_tready == (!m_axis_tvalid || m_axis_tready), "ready")
    `FPA_ASSERT_IMPL(a_pad, i_clk, i_rst_n, m_axis_tdata[39:35] == 5'd0, "pad bits")
endmodule

[tb/fixed_point_alu_tb.sv]
// Self-checking testbench of the signed fixed-point ALU with saturation.
// Depends on fpa_pkg and the fixed_point_alu top level; needs no other file.
module fixed_point_alu_tb;
    localparam int FRAC = 8;
    localparam int N_RANDOM = 1800;
    localparam int LATENCY = 18;
    localparam int LONG_STALL = 200;
    localparam longint MAX_CYCLES = 400000;
    localparam logic signed [63:0] RAW_MAX = 64'sd2147483647;
    localparam logic signed [63:0] RAW_MIN = -64'sd2147483648;

    typedef struct packed {
        fpa_pkg::t_op action;
        logic [31:0]  a;
        logic [31:0]  b;
    } t_alu_req;

    typedef struct packed {
        logic [31:0]      value;
        logic             cmp;
        fpa_pkg::t_status status;
    } t_alu_res;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata = '0;   // action[3:0], operand_a[35:4], operand_b[67:36]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;        // result_value[31:0], compare_true[32], status[34:33]

    t_alu_req pending_reqs[$];
    t_alu_res expected_results[$];
    int       errors = 0;
    longint   cycle_count = 0;
    bit       stimulus_done = 1'b0;
    bit       calm_phase = 1'b0;      // no idling on either side
    bit       sender_hold = 1'b0;     // sender waits for the queue to drain
    bit       in_fire = 1'b0;         // an input item was taken at the last rising edge
    bit       stall_done = 1'b0;      // the long receiver stall has been started
    int       long_stall = 0;         // receiver holds off this many cycles
    int       send_gap = 0;
    int       recv_gap = 0;

    fixed_point_alu #(.FRAC_BITS(FRAC)) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always #6 i_clk = ~i_clk;

    // Saturate a wide signed value to the 32-bit raw range.
    function automatic void saturate(input logic signed [63:0] v,
                                     inout t_alu_res r);
        if (v > RAW_MAX) begin
            r.value = RAW_MAX[31:0];
            r.status = fpa_pkg::ST_OVF;
        end else if (v < RAW_MIN) begin
            r.value = RAW_MIN[31:0];
            r.status = fpa_pkg::ST_OVF;
        end else begin
            r.value = v[31:0];
        end
    endfunction

    function automatic t_alu_res compute_alu(t_alu_req q);
        t_alu_res r;
        logic signed [63:0] sa, sb, sv;
        logic [63:0] ma, mb, p, n, quo, rem;
        logic neg;
        r = '{value: '0, cmp: 1'b0, status: fpa_pkg::ST_OK};
        sa = {{32{q.a[31]}}, q.a};
        sb = {{32{q.b[31]}}, q.b};
        ma = sa < 0 ? -sa : sa;
        mb = sb < 0 ? -sb : sb;
        neg = (sa < 0) != (sb < 0);
        case (q.action)
            fpa_pkg::OP_ADD: saturate(sa + sb, r);
            fpa_pkg::OP_SUB: saturate(sa - sb, r);
            fpa_pkg::OP_MUL: begin
                // Magnitude product, rounded half away from zero.
                p = (ma * mb + (64'd1 << (FRAC - 1))) >> FRAC;
                sv = neg ? -$signed(p) : $signed(p);
                saturate(sv, r);
            end
            fpa_pkg::OP_DIV: begin
                if (sb == 0) begin
                    r.value = sa < 0 ? RAW_MIN[31:0] : RAW_MAX[31:0];
                    r.status = fpa_pkg::ST_DIVZ;
                end else begin
                    n = ma << FRAC;
                    quo = n / mb;
                    rem = n % mb;
                    if (2 * rem >= mb) quo++;
                    sv = neg ? -$signed(quo) : $signed(quo);
                    saturate(sv, r);
                end
            end
            fpa_pkg::OP_GT: r.cmp = sa > sb;
            fpa_pkg::OP_LT: r.cmp = sa < sb;
            fpa_pkg::OP_GE: r.cmp = sa >= sb;
            fpa_pkg::OP_LE: r.cmp = sa <= sb;
            fpa_pkg::OP_EQ: r.cmp = sa == sb;
            fpa_pkg::OP_NE: r.cmp = sa != sb;
            fpa_pkg::OP_MIN: r.value = sa < sb ? q.a : q.b;
            fpa_pkg::OP_MAX: r.value = sa > sb ? q.a : q.b;
            fpa_pkg::OP_INC: saturate(sa + 1, r);
            fpa_pkg::OP_DEC: saturate(sa - 1, r);
            fpa_pkg::OP_TOINT: begin
                // Truncation toward zero works on the magnitude.
                p = ma >> FRAC;
                sv = sa < 0 ? -$signed(p) : $signed(p);
                r.value = sv[31:0];
            end
            default: begin
                p = ma << FRAC;
                sv = sa < 0 ? -$signed(p) : $signed(p);
                saturate(sv, r);
            end
        endcase
        return r;
    endfunction

    // Operands lean toward the edges of the range and toward small values.
    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return 32'h7fff_ffff - $urandom_range(0, 2);
            1: return 32'h8000_0000 + $urandom_range(0, 2);
            2: return $urandom_range(0, 4) - 2;
            3: return ($urandom_range(0, 8000) - 4000);
            4: return ($urandom_range(0, 1 << 20) - (1 << 19));
            default: return $urandom;
        endcase
    endfunction

    task automatic add_req(fpa_pkg::t_op op, logic [31:0] a, logic [31:0] b);
        pending_reqs.push_back('{action: op, a: a, b: b});
    endtask

    // Stimulus: directed corners first, then random items.
    initial begin : stimulus
        t_alu_req q;
        for (int k = 0; k < 16; k++)
            add_req(fpa_pkg::t_op'(k), 32'h7fff_ffff, 32'h8000_0000);
        add_req(fpa_pkg::OP_DIV, 32'h0000_0100, 32'h0000_0000);
        add_req(fpa_pkg::OP_DIV, 32'h8000_0000, 32'h0000_0000);
        add_req(fpa_pkg::OP_MUL, 32'h0000_0080, 32'h0000_0001);  // rounding tie
        add_req(fpa_pkg::OP_MUL, 32'hffff_ff80, 32'h0000_0001);  // negative tie
        add_req(fpa_pkg::OP_DIV, 32'h0000_0001, 32'h0000_0200);  // quotient tie
        add_req(fpa_pkg::OP_INC, 32'h7fff_ffff, 32'h0);
        add_req(fpa_pkg::OP_DEC, 32'h8000_0000, 32'h0);
        add_req(fpa_pkg::OP_MIN, 32'h1234_5678, 32'h1234_5678);
        add_req(fpa_pkg::OP_TOINT, 32'hffff_ff01, 32'hffff_ffff);
        for (int i = 0; i < N_RANDOM; i++) begin
            q.action = fpa_pkg::t_op'($urandom_range(0, 15));
            q.a = pick_operand();
            q.b = ($urandom_range(0, 3) == 0) ? q.a : pick_operand();
            if (q.action == fpa_pkg::OP_DIV && $urandom_range(0, 15) == 0) q.b = '0;
            pending_reqs.push_back(q);
        end
        wait (i_rst_n);
        // Sender pause until every expected result has come back.
        wait (pending_reqs.size() < N_RANDOM / 2);
        sender_hold = 1'b1;
        wait (expected_results.size() == 0);
        @(negedge i_clk);
        sender_hold = 1'b0;
        wait (pending_reqs.size() < 200);
        calm_phase = 1'b1;
        wait (pending_reqs.size() == 0 && !s_axis_tvalid);
        stimulus_done = 1'b1;
    end

    initial begin : reset_seq
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Driver: presents queued items at the falling edge, with random gaps.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && !in_fire) begin
                // Item still on offer; hold it.
            end else if (sender_hold || pending_reqs.size() == 0) begin
                s_axis_tvalid <= 1'b0;
            end else if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                s_axis_tvalid <= 1'b0;
            end else if (!calm_phase && $urandom_range(0, 19) == 0) begin
                send_gap <= $urandom_range(0, 9);
                s_axis_tvalid <= 1'b0;
            end else begin
                s_axis_tdata <= {4'b0, pending_reqs[0].b, pending_reqs[0].a,
                                 pending_reqs[0].action};
                s_axis_tvalid <= 1'b1;
                void'(pending_reqs.pop_front());
            end
        end
    end

    // Receiver backpressure, also changing at the falling edge. Once the
    // random items have started to flow, the receiver holds off for a long
    // stretch so that the row fills up and stalls the sender.
    always @(negedge i_clk) begin
        if (!stall_done && i_rst_n && pending_reqs.size() < N_RANDOM) begin
            stall_done <= 1'b1;
            long_stall <= LONG_STALL;
            m_axis_tready <= 1'b0;
        end else if (long_stall > 0) begin
            long_stall <= long_stall - 1;
            m_axis_tready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            m_axis_tready <= 1'b0;
        end else if (!calm_phase && $urandom_range(0, 19) == 0) begin
            recv_gap <= $urandom_range(0, 9);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Monitor: predicts on input acceptance, checks on output acceptance.
    always @(posedge i_clk) begin
        t_alu_res got, want;
        t_alu_req req;
        cycle_count <= cycle_count + 1;
        in_fire <= i_rst_n && s_axis_tvalid && s_axis_tready;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            req.action = fpa_pkg::t_op'(s_axis_tdata[3:0]);
            req.a = s_axis_tdata[35:4];
            req.b = s_axis_tdata[67:36];
            expected_results.push_back(compute_alu(req));
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.value = m_axis_tdata[31:0];
            got.cmp = m_axis_tdata[32];
            got.status = fpa_pkg::t_status'(m_axis_tdata[34:33]);
            if (expected_results.size() == 0) begin
                $error("unexpected result item %h", m_axis_tdata);
                errors++;
            end else begin
                want = expected_results.pop_front();
                if (got.value !== want.value) begin
                    $error("result_value expected %h actual %h", want.value, got.value);
                    errors++;
                end
                if (got.cmp !== want.cmp) begin
                    $error("compare_true expected %b actual %b", want.cmp, got.cmp);
                    errors++;
                end
                if (got.status !== want.status) begin
                    $error("status expected %0d actual %0d", want.status, got.status);
                    errors++;
                end
            end
        end
    end

    initial begin : finish_seq
        wait (stimulus_done && expected_results.size() == 0);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (errors == 0 && expected_results.size() == 0)
            $display("PASS fixed_point_alu");
        else
            $display("FAIL fixed_point_alu");
        $finish;
    end

    initial begin : watchdog
        wait (cycle_count >= MAX_CYCLES);
        $display("FAIL fixed_point_alu");
        $finish;
    end
endmodule
